// ===== src/i2cms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and constants for the i2c master bit sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam logic [7:0] ACK_WAIT_LIMIT_RST = 8'd250;
    localparam logic [3:0] LAST_BIT_IDX       = 4'd8;

    // command codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_START    = 3'd1,
        KIND_STOP     = 3'd2,
        KIND_WRITE    = 3'd3,
        KIND_WAIT_ACK = 3'd4,
        KIND_READ     = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST1     = 4'd1,
        PH_ST2     = 4'd2,
        PH_SP1     = 4'd3,
        PH_SP2     = 4'd4,
        PH_WR_HI   = 4'd5,
        PH_WR_LO   = 4'd6,
        PH_AK_HI   = 4'd7,
        PH_AK_POLL = 4'd8,
        PH_AK_END  = 4'd9,
        PH_RD_LO   = 4'd10,
        PH_RD_HI   = 4'd11,
        PH_RA_SDA  = 4'd12,
        PH_RA_HI   = 4'd13,
        PH_RA_LO   = 4'd14,
        PH_RA_REL  = 4'd15
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       busy_res;
        logic       cmd_done;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } result_t;

endpackage

// ===== src/i2c_master_bit_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// tick-driven i2c master line sequencer with valid/stall channels
// ----------------------------------------------------------------------------
// usage:
//   every input transfer is one bus delay slot: it carries the sampled sda
//   level and, while the sequencer is idle, may start a command (start, stop,
//   write byte, wait ack, read byte). every input transfer yields exactly one
//   output transfer with the scl/sda levels for that slot, busy, done, the
//   last received byte and the ack-timeout flag.
//   path: an accepted tick passes the input register, then the result
//   register, before it is shown on out_valid.
//   throughput: one tick per cycle unless stalled, set by the combinational
//   step logic that sits between the input register and the result register.
//   stall: while out_stall holds a full result register, the input register
//   stays full and in_stall rises; the shown result holds until transferred.
//   reset: lines released (scl and sda high), sequencer idle, rx byte and
//   failure flag cleared, ack_wait_limit back to 250.
//   configuration: cfg_wr_en/cfg_wr_data write ack_wait_limit; write only
//   while no tick is in flight.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // tick input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] kind,
    input  logic [7:0] tx_byte,
    input  logic       send_ack,
    input  logic       sda_in,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       cmd_done,
    output logic [7:0] rx_byte,
    output logic       ack_failed
);

    logic [7:0] limit_reg;
    item_t      in_item;
    item_t      item_q;
    logic       step_en;
    logic       out_free;
    result_t    step_res;
    result_t    res_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_item = '{kind: kind, tx_byte: tx_byte, send_ack: send_ack, sda_in: sda_in};

    // result register is free when empty or being transferred this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= ACK_WAIT_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    i2cms_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_free (out_free),
        .step_en  (step_en),
        .item_q   (item_q)
    );

    // sequencer state advances once per tick moved into the result register
    i2cms_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .item           (item_q),
        .ack_wait_limit (limit_reg),
        .res            (step_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = res_reg.scl_level;
    assign sda_drive  = res_reg.sda_drive;
    assign busy_res   = res_reg.busy_res;
    assign cmd_done   = res_reg.cmd_done;
    assign rx_byte    = res_reg.rx_byte;
    assign ack_failed = res_reg.ack_failed;

endmodule

// ===== src/i2cms_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_in_stage
// input register for one tick item, held while the next stage is full
// ----------------------------------------------------------------------------
module i2cms_in_stage
    import i2cms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    input  logic  out_free,
    output logic  step_en,
    output item_t item_q
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign step_en  = valid_reg && out_free;
    assign in_stall = valid_reg && !out_free;
    assign take     = in_valid && !in_stall;
    assign item_q   = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (step_en)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/i2cms_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_seq
// line sequencer state and the per-tick next-state logic
// ----------------------------------------------------------------------------
module i2cms_seq
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  item_t      item,
    input  logic [7:0] ack_wait_limit,
    output result_t    res
);

    phase_t     phase_reg,   phase_next;
    kind_t      command_reg, command_next;
    logic [3:0] bit_idx_reg, bit_idx_next;
    logic [7:0] shift_reg,   shift_next;
    logic [7:0] poll_reg,    poll_next;
    logic       ack_reg,     ack_next;
    logic       scl_reg,     scl_next;
    logic       sda_reg,     sda_next;
    logic [7:0] rx_reg,      rx_next;
    logic       fail_reg,    fail_next;
    logic       busy;
    logic       done;
    logic [3:0] bit_inc;
    logic [7:0] poll_inc;

    assign bit_inc  = bit_idx_reg + 4'd1;
    assign poll_inc = poll_reg + 8'd1;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        poll_next    = poll_reg;
        ack_next     = ack_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rx_next      = rx_reg;
        fail_next    = fail_reg;
        busy         = 1'b1;
        done         = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                command_next = kind_t'(item.kind);
                unique case (kind_t'(item.kind))
                    KIND_START:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        phase_next = PH_ST1;
                    end
                    KIND_STOP:
                    begin
                        sda_next   = 1'b0;
                        phase_next = PH_SP1;
                    end
                    KIND_WRITE:
                    begin
                        shift_next   = item.tx_byte;
                        bit_idx_next = 4'd0;
                        sda_next     = item.tx_byte[7];
                        phase_next   = PH_WR_HI;
                    end
                    KIND_WAIT_ACK:
                    begin
                        sda_next   = 1'b1;
                        poll_next  = 8'd0;
                        phase_next = PH_AK_HI;
                    end
                    KIND_READ:
                    begin
                        ack_next     = item.send_ack;
                        sda_next     = 1'b1;
                        scl_next     = 1'b1;
                        shift_next   = {7'd0, item.sda_in};
                        bit_idx_next = 4'd1;
                        phase_next   = PH_RD_LO;
                    end
                    default:
                    begin
                        command_next = KIND_NONE;
                        busy         = 1'b0;
                    end
                endcase
            end
            PH_ST1:
            begin
                sda_next   = 1'b0;
                phase_next = PH_ST2;
            end
            PH_ST2:
            begin
                scl_next = 1'b0;
                done     = 1'b1;
            end
            PH_SP1:
            begin
                scl_next   = 1'b1;
                phase_next = PH_SP2;
            end
            PH_SP2:
            begin
                sda_next = 1'b1;
                if (command_reg == KIND_WAIT_ACK)
                begin
                    phase_next = PH_AK_END;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_WR_HI:
            begin
                scl_next   = 1'b1;
                phase_next = PH_WR_LO;
            end
            PH_WR_LO:
            begin
                scl_next     = 1'b0;
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_idx_next = bit_inc;
                if (bit_inc >= LAST_BIT_IDX)
                begin
                    sda_next = 1'b1;
                    done     = 1'b1;
                end
                else
                begin
                    sda_next   = shift_reg[6];
                    phase_next = PH_WR_HI;
                end
            end
            PH_AK_HI:
            begin
                scl_next   = 1'b1;
                phase_next = PH_AK_POLL;
            end
            PH_AK_POLL:
            begin
                if (!item.sda_in)
                begin
                    scl_next  = 1'b0;
                    fail_next = 1'b0;
                    done      = 1'b1;
                end
                else
                begin
                    poll_next = poll_inc;
                    // timeout: run a stop, then flag the failure
                    if (poll_inc > ack_wait_limit)
                    begin
                        sda_next   = 1'b0;
                        phase_next = PH_SP1;
                    end
                end
            end
            PH_AK_END:
            begin
                scl_next  = 1'b0;
                fail_next = 1'b1;
                done      = 1'b1;
            end
            PH_RD_LO:
            begin
                scl_next   = 1'b0;
                phase_next = (bit_idx_reg >= LAST_BIT_IDX) ? PH_RA_SDA : PH_RD_HI;
            end
            PH_RD_HI:
            begin
                scl_next     = 1'b1;
                shift_next   = {shift_reg[6:0], item.sda_in};
                bit_idx_next = bit_inc;
                phase_next   = PH_RD_LO;
            end
            PH_RA_SDA:
            begin
                sda_next   = !ack_reg;
                phase_next = PH_RA_HI;
            end
            PH_RA_HI:
            begin
                scl_next   = 1'b1;
                phase_next = PH_RA_LO;
            end
            PH_RA_LO:
            begin
                scl_next = 1'b0;
                if (ack_reg)
                begin
                    phase_next = PH_RA_REL;
                end
                else
                begin
                    rx_next = shift_reg;
                    done    = 1'b1;
                end
            end
            PH_RA_REL:
            begin
                sda_next = 1'b1;
                rx_next  = shift_reg;
                done     = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
                busy       = 1'b0;
            end
        endcase
        if (done)
        begin
            phase_next   = PH_IDLE;
            command_next = KIND_NONE;
        end
    end

    // result of this tick
    always_comb
    begin
        res.scl_level  = scl_next;
        res.sda_drive  = sda_next;
        res.busy_res   = busy;
        res.cmd_done   = done;
        res.rx_byte    = rx_next;
        res.ack_failed = fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            command_reg <= KIND_NONE;
            bit_idx_reg <= 4'd0;
            shift_reg   <= 8'd0;
            poll_reg    <= 8'd0;
            ack_reg     <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            rx_reg      <= 8'd0;
            fail_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            poll_reg    <= poll_next;
            ack_reg     <= ack_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            rx_reg      <= rx_next;
            fail_reg    <= fail_next;
        end
    end

endmodule

// ===== src/i2cms_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_checker
// port-level checks for the i2c master bit sequencer
// ----------------------------------------------------------------------------
module i2cms_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       scl_level,
    input logic       sda_drive,
    input logic       busy_res,
    input logic       cmd_done,
    input logic [7:0] rx_byte,
    input logic       ack_failed
);

    // a finishing tick always belongs to a command
    a_done_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!cmd_done || busy_res))
        else $error("cmd_done without busy_res");

    // with the result register empty the input side never stalls
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while result register empty");

    // a stalled result keeps its contents
    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(scl_level)
            && $stable(sda_drive) && $stable(busy_res) && $stable(cmd_done)
            && $stable(rx_byte) && $stable(ack_failed)))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (.*);

// ===== dv/i2c_master_bit_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core_tb
// self-checking bench for the tick-driven i2c master line sequencer: a
// cycle-exact line predictor runs beside the block, every tick transfer is
// scored field by field, and bus transactions (start, address write, ack
// wait, reads, stop) run under several ack limits and idle/stall patterns
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core_tb;
    import i2cms_pkg::*;

    // ------------------------------------------------------------------------
    // line predictor and store of expected line states
    // ------------------------------------------------------------------------
    class i2c_line_scoreboard;
        logic [7:0] wait_limit;
        phase_t     ph;
        logic [2:0] cmd;
        logic [3:0] bit_idx;
        logic [7:0] shreg;
        logic [7:0] polls;
        logic       ack_sel;
        logic       scl_q;
        logic       sda_q;
        logic [7:0] rx_q;
        logic       fail_q;
        result_t    line_q[$];
        int         mismatches;
        int         ticks;
        int         cmds;
        int         reads_done;
        int         ack_waits;
        int         timeouts;

        function new();
            wait_limit = ACK_WAIT_LIMIT_RST;
            ph         = PH_IDLE;
            cmd        = KIND_NONE;
            bit_idx    = '0;
            shreg      = '0;
            polls      = '0;
            ack_sel    = 1'b0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            rx_q       = '0;
            fail_q     = 1'b0;
            mismatches = 0;
            ticks      = 0;
            cmds       = 0;
            reads_done = 0;
            ack_waits  = 0;
            timeouts   = 0;
        endfunction

        function void set_limit(input logic [7:0] v);
            wait_limit = v;
        endfunction

        function bit is_idle();
            return ph == PH_IDLE;
        endfunction

        function bit in_ack_poll();
            return ph == PH_AK_POLL;
        endfunction

        function int pending();
            return line_q.size();
        endfunction

        // advance the predicted sequencer by one accepted tick
        function void note_tick(input item_t it);
            logic busy;
            logic done;
            busy = 1'b1;
            done = 1'b0;
            ticks++;
            case (ph)
                PH_IDLE: begin
                    cmd = it.kind;
                    case (it.kind)
                        KIND_START: begin
                            scl_q = 1'b1;
                            sda_q = 1'b1;
                            ph    = PH_ST1;
                        end
                        KIND_STOP: begin
                            sda_q = 1'b0;
                            ph    = PH_SP1;
                        end
                        KIND_WRITE: begin
                            shreg   = it.tx_byte;
                            bit_idx = '0;
                            sda_q   = shreg[7];
                            ph      = PH_WR_HI;
                        end
                        KIND_WAIT_ACK: begin
                            sda_q = 1'b1;
                            polls = '0;
                            ph    = PH_AK_HI;
                            ack_waits++;
                        end
                        KIND_READ: begin
                            ack_sel = it.send_ack;
                            sda_q   = 1'b1;
                            scl_q   = 1'b1;
                            shreg   = {7'd0, it.sda_in};
                            bit_idx = 4'd1;
                            ph      = PH_RD_LO;
                        end
                        default: begin
                            cmd  = KIND_NONE;
                            busy = 1'b0;
                        end
                    endcase
                    if (busy)
                        cmds++;
                end
                PH_ST1: begin
                    sda_q = 1'b0;
                    ph    = PH_ST2;
                end
                PH_ST2: begin
                    scl_q = 1'b0;
                    done  = 1'b1;
                end
                PH_SP1: begin
                    scl_q = 1'b1;
                    ph    = PH_SP2;
                end
                PH_SP2: begin
                    sda_q = 1'b1;
                    if (cmd == KIND_WAIT_ACK)
                        ph = PH_AK_END;
                    else
                        done = 1'b1;
                end
                PH_WR_HI: begin
                    scl_q = 1'b1;
                    ph    = PH_WR_LO;
                end
                PH_WR_LO: begin
                    scl_q   = 1'b0;
                    shreg   = {shreg[6:0], 1'b0};
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx >= LAST_BIT_IDX) begin
                        sda_q = 1'b1;
                        done  = 1'b1;
                    end
                    else begin
                        sda_q = shreg[7];
                        ph    = PH_WR_HI;
                    end
                end
                PH_AK_HI: begin
                    scl_q = 1'b1;
                    ph    = PH_AK_POLL;
                end
                PH_AK_POLL: begin
                    if (!it.sda_in) begin
                        scl_q  = 1'b0;
                        fail_q = 1'b0;
                        done   = 1'b1;
                    end
                    else begin
                        polls = polls + 8'd1;
                        if (polls > wait_limit) begin
                            sda_q = 1'b0;
                            ph    = PH_SP1;
                            timeouts++;
                        end
                    end
                end
                PH_AK_END: begin
                    scl_q  = 1'b0;
                    fail_q = 1'b1;
                    done   = 1'b1;
                end
                PH_RD_LO: begin
                    scl_q = 1'b0;
                    ph    = (bit_idx >= LAST_BIT_IDX) ? PH_RA_SDA : PH_RD_HI;
                end
                PH_RD_HI: begin
                    scl_q   = 1'b1;
                    shreg   = {shreg[6:0], it.sda_in};
                    bit_idx = bit_idx + 4'd1;
                    ph      = PH_RD_LO;
                end
                PH_RA_SDA: begin
                    sda_q = ~ack_sel;
                    ph    = PH_RA_HI;
                end
                PH_RA_HI: begin
                    scl_q = 1'b1;
                    ph    = PH_RA_LO;
                end
                PH_RA_LO: begin
                    scl_q = 1'b0;
                    if (ack_sel)
                        ph = PH_RA_REL;
                    else begin
                        rx_q = shreg;
                        done = 1'b1;
                        reads_done++;
                    end
                end
                PH_RA_REL: begin
                    sda_q = 1'b1;
                    rx_q  = shreg;
                    done  = 1'b1;
                    reads_done++;
                end
                default: begin
                    ph   = PH_IDLE;
                    busy = 1'b0;
                end
            endcase
            if (done) begin
                ph  = PH_IDLE;
                cmd = KIND_NONE;
            end
            line_q.push_back('{scl_level: scl_q, sda_drive: sda_q, busy_res: busy,
                               cmd_done: done, rx_byte: rx_q, ack_failed: fail_q});
        endfunction

        // compare one delivered result with the oldest prediction
        function void check_result(input result_t got);
            result_t want;
            if (line_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: %p", $realtime, got);
                return;
            end
            want = line_q.pop_front();
            if (got.scl_level !== want.scl_level || got.sda_drive !== want.sda_drive ||
                got.busy_res !== want.busy_res || got.cmd_done !== want.cmd_done ||
                got.rx_byte !== want.rx_byte || got.ack_failed !== want.ack_failed) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: line mismatch", $realtime);
                    $display("    expected scl %b sda %b busy %b done %b rx %02h fail %b",
                             want.scl_level, want.sda_drive, want.busy_res,
                             want.cmd_done, want.rx_byte, want.ack_failed);
                    $display("    actual   scl %b sda %b busy %b done %b rx %02h fail %b",
                             got.scl_level, got.sda_drive, got.busy_res,
                             got.cmd_done, got.rx_byte, got.ack_failed);
                end
            end
        endfunction

        function void check_leftover();
            if (line_q.size() != 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0d predicted line states never delivered", line_q.size());
            end
        endfunction
    endclass

    // one queued bus command plus how many high polls the target holds off
    typedef struct {
        item_t       tick;
        int unsigned ack_delay;
    } bus_op_t;

    localparam int CLK_HALF   = 5;
    localparam int MAX_CYCLES = 400000;
    localparam int RAND_TICKS = 60;

    // ------------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
    logic       out_valid;
    logic       out_stall;
    logic       scl_level;
    logic       sda_drive;
    logic       busy_res;
    logic       cmd_done;
    logic [7:0] rx_byte;
    logic       ack_failed;

    i2c_line_scoreboard sb;
    bus_op_t            op_plan[$];
    int                 random_ticks_left;
    int unsigned        polls_high_left;
    int                 idle_mode;
    int                 cycle_count;
    int                 settings_used;

    i2c_master_bit_sequencer_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .tx_byte     (tx_byte),
        .send_ack    (send_ack),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_level   (scl_level),
        .sda_drive   (sda_drive),
        .busy_res    (busy_res),
        .cmd_done    (cmd_done),
        .rx_byte     (rx_byte),
        .ack_failed  (ack_failed)
    );

    // free-running clock, 10 ns period
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // run guard: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("run limit of %0d cycles reached", MAX_CYCLES);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // idle patterns
    //   0: no idling, 1: sender idle 80 %, 2: receiver stalls 80 %, 3: both 12 %
    // ------------------------------------------------------------------------
    function automatic bit sender_gap();
        if (idle_mode == 1)
            return $urandom_range(0, 99) < 80;
        if (idle_mode == 3)
            return $urandom_range(0, 99) < 12;
        return 1'b0;
    endfunction

    function automatic bit receiver_stall();
        if (idle_mode == 2)
            return $urandom_range(0, 99) < 80;
        if (idle_mode == 3)
            return $urandom_range(0, 99) < 12;
        return 1'b0;
    endfunction

    // result side: score each delivered transfer, then pick next stall level
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{scl_level: scl_level, sda_drive: sda_drive,
                              busy_res: busy_res, cmd_done: cmd_done,
                              rx_byte: rx_byte, ack_failed: ack_failed});
        out_stall <= receiver_stall();
    end

    // ------------------------------------------------------------------------
    // stimulus planning
    // ------------------------------------------------------------------------

    // high polls before the target pulls sda: quick acks, late acks right at
    // the limit, and one past the limit to force a timeout (wrap at 255)
    function automatic int unsigned pick_ack_delay();
        int unsigned lim;
        int unsigned r;
        lim = {24'd0, sb.wait_limit};
        r   = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 2);
        if (r < 6)
            return $urandom_range(0, lim);
        if (r < 8)
            return lim;
        return lim + 1;
    endfunction

    function automatic void add_op(input logic [2:0] k, input logic [7:0] tx,
                                   input logic ack, input int delay = -1);
        bus_op_t op;
        op.tick.kind     = k;
        op.tick.tx_byte  = tx;
        op.tick.send_ack = ack;
        op.tick.sda_in   = 1'($urandom_range(0, 1));
        op.ack_delay     = 0;
        if (k == KIND_WAIT_ACK)
            op.ack_delay = (delay < 0) ? pick_ack_delay() : unsigned'(delay);
        op_plan.push_back(op);
    endfunction

    // mostly well-formed bus transactions, sometimes a lone or broken one
    function automatic void plan_transaction();
        int n;
        if ($urandom_range(0, 4) == 0) begin
            add_op(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
            return;
        end
        add_op(KIND_START, 8'($urandom), 1'($urandom));
        add_op(KIND_WRITE, 8'($urandom), 1'($urandom));
        add_op(KIND_WAIT_ACK, 8'($urandom), 1'($urandom));
        n = int'($urandom_range(0, 3));
        repeat (n) begin
            if ($urandom_range(0, 1)) begin
                add_op(KIND_WRITE, 8'($urandom), 1'($urandom));
                add_op(KIND_WAIT_ACK, 8'($urandom), 1'($urandom));
            end
            else
                add_op(KIND_READ, 8'($urandom), 1'b1);
        end
        if ($urandom_range(0, 1))
            add_op(KIND_READ, 8'($urandom), 1'b0);
        // now and then leave the bus without a stop
        if ($urandom_range(0, 9) != 0)
            add_op(KIND_STOP, 8'($urandom), 1'($urandom));
    endfunction

    // choose the next tick; the predictor already holds every accepted tick,
    // so its phase is exactly the one this tick will meet
    function automatic bit next_tick(output item_t it);
        bus_op_t op;
        bit      counted;
        it.kind     = KIND_NONE;
        it.tx_byte  = 8'($urandom);
        it.send_ack = 1'($urandom_range(0, 1));
        it.sda_in   = 1'($urandom_range(0, 1));
        counted     = 1'b1;
        if (sb.is_idle()) begin
            if (op_plan.size() == 0 && random_ticks_left > 0)
                plan_transaction();
            if (op_plan.size() == 0)
                return 1'b0;
            op              = op_plan.pop_front();
            it              = op.tick;
            polls_high_left = op.ack_delay;
            // none and unused codes just hold the lines
            counted = it.kind inside {KIND_START, KIND_STOP, KIND_WRITE,
                                      KIND_WAIT_ACK, KIND_READ};
        end
        else begin
            // commands offered mid-command must be ignored
            if ($urandom_range(0, 9) < 3)
                it.kind = 3'($urandom_range(0, 7));
            if (sb.in_ack_poll()) begin
                it.sda_in = (polls_high_left != 0);
                if (polls_high_left != 0)
                    polls_high_left--;
            end
        end
        if (counted && random_ticks_left > 0)
            random_ticks_left--;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // feed ticks until the plan and random budget are used up and the
    // sequencer is back at idle, then drain all results
    task automatic run_phase(input int mode, input int rand_ticks);
        item_t cur;
        bit    have;
        bit    accepted;
        idle_mode         = mode;
        random_ticks_left = rand_ticks;
        have              = 1'b0;
        forever begin
            @(posedge clk);
            accepted = in_valid && !in_stall;
            if (accepted) begin
                sb.note_tick(cur);
                have = 1'b0;
            end
            if (!have)
                have = next_tick(cur);
            if (!have) begin
                in_valid <= 1'b0;
                break;
            end
            // stalled transfer keeps its payload
            if (in_valid && !accepted)
                continue;
            if (sender_gap())
                in_valid <= 1'b0;
            else begin
                in_valid <= 1'b1;
                kind     <= cur.kind;
                tx_byte  <= cur.tx_byte;
                send_ack <= cur.send_ack;
                sda_in   <= cur.sda_in;
            end
        end
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // limit writes only happen with no tick in flight
    task automatic write_limit(input logic [7:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(v);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] limits[7];
        sb            = new();
        cycle_count   = 0;
        settings_used = 1;
        idle_mode     = 0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        kind        <= KIND_NONE;
        tx_byte     <= '0;
        send_ack    <= 1'b0;
        sda_in      <= 1'b0;
        out_stall   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass at the reset limit: every command, byte extremes,
        // ack and nack reads, idle with none and unused codes
        add_op(KIND_START, 8'h00, 1'b0);
        add_op(KIND_WRITE, 8'h00, 1'b0);
        add_op(KIND_WAIT_ACK, 8'h00, 1'b0, 0);
        add_op(KIND_WRITE, 8'hFF, 1'b1);
        add_op(KIND_WAIT_ACK, 8'hFF, 1'b1, 2);
        add_op(KIND_READ, 8'h00, 1'b1);
        add_op(KIND_READ, 8'hFF, 1'b0);
        add_op(3'd6, 8'h55, 1'b1);
        add_op(3'd7, 8'hAA, 1'b0);
        add_op(KIND_NONE, 8'h00, 1'b0);
        add_op(KIND_STOP, 8'h00, 1'b0);
        add_op(KIND_WRITE, 8'h80, 1'b0);
        add_op(KIND_WAIT_ACK, 8'h00, 1'b0, 250);
        add_op(KIND_STOP, 8'hFF, 1'b1);
        run_phase(0, 0);

        // zero limit: ack on the first poll, then a timeout on the first
        // high poll (stop, scl low, failure flag), then a clean ack clears it
        write_limit(8'd0);
        add_op(KIND_WAIT_ACK, 8'h00, 1'b0, 0);
        add_op(KIND_WAIT_ACK, 8'h00, 1'b0, 1);
        add_op(KIND_WAIT_ACK, 8'h00, 1'b0, 0);
        run_phase(0, RAND_TICKS);

        // remaining settings, full-limit wrap case among them
        limits = '{8'd255, 8'd3, 8'd250, 8'd1, 8'd6, 8'd2, 8'd128};
        for (int i = 0; i < 7; i++) begin
            write_limit(limits[i]);
            run_phase((i + 1) % 4, (i == 6) ? RAND_TICKS / 2 : RAND_TICKS);
        end

        repeat (5) @(posedge clk);
        sb.check_leftover();
        $display("%0d ticks scored: %0d commands, %0d reads, %0d ack waits (%0d timed out)",
                 sb.ticks, sb.cmds, sb.reads_done, sb.ack_waits, sb.timeouts);
        $display("%0d ack limit settings under four idle patterns, %0d mismatches",
                 settings_used, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
